>>> hw/rtl/f2u8_pkg.sv
// Package for the float-to-unorm8 blend weight converter.
// Holds payload structs, register indexes and the conversion function.
// No dependencies.
`default_nettype none
package f2u8_pkg;
    localparam int unsigned MAX_LANES = 4;
    localparam logic [3:0] USAGE_BLEND = 4'd7;
    localparam logic [3:0] USAGE_BLEND_IMPL = 4'd8;

    typedef enum logic [1:0] {
        REG_SRC_LANES = 2'd0,
        REG_DST_LANES = 2'd1,
        REG_SRC_USAGE = 2'd2,
        REG_DST_USAGE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        stream_end;
    } t_in;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [2:0] lane_index;
        logic       vertex_end;
        logic       run_last;
        logic       batch_end;
    } t_out;

    // x*255 rounded to nearest even in single precision, truncated toward
    // zero, low byte. NaN or |p| >= 2^31 gives 0.
    function automatic logic [7:0] to_unorm8(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] m;
        logic [31:0] prod;
        logic [9:0]  pe;
        logic [24:0] pm;
        logic        rnd;
        logic [63:0] sh;
        logic [31:0] mag;
        logic [7:0]  res;
        e = bits[30:23];
        m = (e == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
        prod = 32'(m) * 32'd255;
        res = 8'd0;
        // product has 32 bits; pe is exponent of bit 31 minus bias, unbiased
        // value = prod * 2^(e_eff-150)
        if (e == 8'hFF) begin
            res = 8'd0;
        end else if (prod == 32'd0) begin
            res = 8'd0;
        end else begin
            // normalize: 24-bit significand from prod
            if (prod[31]) begin
                rnd = prod[7] & (prod[6:0] != 7'd0 | prod[8]);
                pm = {1'b0, prod[31:8]} + 25'(rnd);
                pe = 10'((e == 8'd0) ? 1 : e) + 10'd8;
            end else if (prod[30]) begin
                rnd = prod[6] & (prod[5:0] != 6'd0 | prod[7]);
                pm = {1'b0, prod[30:7]} + 25'(rnd);
                pe = 10'((e == 8'd0) ? 1 : e) + 10'd7;
            end else begin
                // subnormal inputs: prod small, value tiny -> byte 0
                pm = 25'd0;
                pe = 10'd0;
            end
            if (pm[24]) begin
                pm = pm >> 1;
                pe = pe + 10'd1;
            end
            // value = pm * 2^(pe-150); need pe-150+23 < 31 for in range
            if (pe >= 10'd158) begin
                res = 8'd0;
            end else if (pe < 10'd127) begin
                res = 8'd0;
            end else begin
                sh = {40'd0, pm[23:0]} << (pe - 10'd127);
                mag = sh[54:23];
                res = bits[31] ? 8'(-mag) : mag[7:0];
            end
        end
        return res;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/float_to_unorm8_blend_weights_core.sv
// An accepted input passes through an input register and a result register. One
// transaction per cycle while the output does not stall; a vertex-closing lane in
// implied-last mode gives two results and holds the input stage until the second,
// pending result has gone to the output, longer while the output stalls.
// Reset (synchronous, active low) restores lane counts 4, usages 0, clears
// the lane counter, weight sum and all valid flags.
`default_nettype none
module float_to_unorm8_blend_weights_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire f2u8_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output f2u8_pkg::t_out      o_data,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [3:0]     i_cfg_data
);
    import f2u8_pkg::*;

    logic [2:0] r_src_lanes, r_dst_lanes;
    logic [3:0] r_src_usage, r_dst_usage;
    logic [2:0] r_lane, n_lane;
    logic [7:0] r_sum, n_sum;
    // input register stage
    logic       r_iv;
    t_in        r_in;
    // result register and pending implied byte
    logic       r_ov;
    t_out       r_out;
    logic       r_pv;
    t_out       r_pend;

    logic       mode_a, mode_b, mode_c, matched;
    logic [2:0] count;
    logic [7:0] b, s;
    logic       vend, two, one;
    t_out       res0, res1;
    logic       out_free, adv;

    always_comb begin
        mode_a = (r_src_lanes == r_dst_lanes) && (32'(r_src_lanes) <= MAX_LANES);
        mode_b = !mode_a && r_src_usage == USAGE_BLEND && r_dst_usage == USAGE_BLEND_IMPL
              && (4'(r_src_lanes) + 4'd1 == 4'(r_dst_lanes))
              && (32'(r_dst_lanes) <= MAX_LANES);
        mode_c = !mode_a && !mode_b
              && (r_src_usage == USAGE_BLEND_IMPL || r_dst_usage == USAGE_BLEND)
              && (4'(r_dst_lanes) + 4'd1 == 4'(r_src_lanes))
              && (32'(r_src_lanes) <= MAX_LANES);
        matched = mode_a || mode_b || mode_c;
        count = mode_a ? r_src_lanes : r_dst_lanes;
        b = to_unorm8(r_in.float_bits);
        vend = (4'(r_lane) + 4'd1) >= 4'(count);
        s = r_sum + b;
        two = 1'b0;
        one = 1'b0;
        res0 = '0;
        res1 = '0;
        n_lane = r_lane;
        n_sum = r_sum;
        if (matched) begin
            if (mode_c && count == 3'd0) begin
                one = 1'b1;
                res0 = '{byte_value: 8'd255 - r_sum, lane_index: 3'd0,
                         vertex_end: 1'b1, run_last: 1'b1,
                         batch_end: r_in.stream_end};
                n_lane = '0;
                n_sum = '0;
            end else if (count != 3'd0) begin
                one = 1'b1;
                if (vend && mode_c) begin
                    two = 1'b1;
                    res0 = '{byte_value: b, lane_index: r_lane, vertex_end: 1'b0,
                             run_last: 1'b0, batch_end: 1'b0};
                    res1 = '{byte_value: 8'd255 - s, lane_index: count,
                             vertex_end: 1'b1, run_last: 1'b1,
                             batch_end: r_in.stream_end};
                end else begin
                    res0 = '{byte_value: b, lane_index: r_lane, vertex_end: vend,
                             run_last: 1'b1, batch_end: r_in.stream_end};
                end
                n_lane = vend ? 3'd0 : r_lane + 3'd1;
                n_sum = vend ? 8'd0 : s;
            end
        end
        if (r_in.stream_end) begin
            n_lane = '0;
            n_sum = '0;
        end
    end

    // Output slot frees when empty or being taken; pending byte goes first.
    assign out_free = !r_ov || !i_stall;
    assign adv = r_iv && out_free && !r_pv;
    assign o_stall = r_iv && !adv;
    assign o_valid = r_ov;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_lanes <= 3'd4;
            r_dst_lanes <= 3'd4;
            r_src_usage <= '0;
            r_dst_usage <= '0;
            r_lane <= '0;
            r_sum <= '0;
            r_iv <= 1'b0;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_SRC_LANES: r_src_lanes <= i_cfg_data[2:0];
                    REG_DST_LANES: r_dst_lanes <= i_cfg_data[2:0];
                    REG_SRC_USAGE: r_src_usage <= i_cfg_data;
                    REG_DST_USAGE: r_dst_usage <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) r_iv <= 1'b1;
            else if (adv) r_iv <= 1'b0;
            if (out_free) begin
                if (r_pv) begin
                    r_ov <= 1'b1;
                    r_pv <= 1'b0;
                end else begin
                    r_ov <= adv && one;
                    r_pv <= adv && two;
                end
            end
            if (adv) begin
                r_lane <= n_lane;
                r_sum <= n_sum;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_in <= i_data;
        if (out_free) begin
            if (r_pv) r_out <= r_pend;
            else if (adv) r_out <= res0;
        end
        if (adv) r_pend <= res1;
    end

`ifndef NO_ASSERTIONS
    // Pending implied byte always trails a shown result.
    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> r_ov) else $error("pending byte without shown result");
    // Input stage never drains while a pending byte is queued.
    a_no_adv_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> !adv) else $error("advance with pending byte");
    // A two-result lane leaves its first byte not closing the vertex.
    a_first_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> !r_out.run_last) else $error("first of pair marked last");
`endif
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for float_to_unorm8_blend_weights_core.
// Depends on f2u8_pkg and the core RTL; it predicts every output byte from
// its own bit-exact float model and checks results in order.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import f2u8_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [3:0]  cfg_data = '0;
    logic        o_stall;
    logic        o_valid;
    t_out        o_data;

    float_to_unorm8_blend_weights_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_stall    (o_stall),
        .i_data     (in_data),
        .o_valid    (o_valid),
        .i_stall    (out_stall),
        .o_data     (o_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Mirror of the block's configuration and per-vertex state.
    logic [2:0] m_src_lanes = 3'd4;
    logic [2:0] m_dst_lanes = 3'd4;
    logic [3:0] m_src_usage = 4'd0;
    logic [3:0] m_dst_usage = 4'd0;
    logic [2:0] lane_cnt = '0;
    logic [7:0] vtx_sum = '0;

    t_in  pending_lanes[$];
    t_out expected_bytes[$];

    int   fail_cnt = 0;
    int   lanes_in = 0;
    int   bytes_out = 0;
    int   cycles = 0;
    bit   sent = 1'b0;
    bit   hold_off = 1'b0;
    bit   quiet = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;

    // x*255 rounded to nearest even at 24 significant bits, truncated toward
    // zero; NaN, infinity and magnitudes of 2^31 or more give 0.
    function automatic logic [7:0] unorm8_of(logic [31:0] f);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int          e;
        int          l;
        int          k;
        int          x;
        e = int'(f[30:23]);
        if (e == 255) return 8'd0;
        p = {40'd0, (e != 0), f[22:0]} * 64'd255;
        if (p == 64'd0) return 8'd0;
        if (e == 0) e = 1;
        l = 0;
        for (int i = 0; i < 64; i++) if (p[i]) l = i + 1;
        k = 0;
        q = p;
        if (l > 24) begin
            k = l - 24;
            q = p >> k;
            rem = p & ((64'd1 << k) - 64'd1);
            half = 64'd1 << (k - 1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            if (q[24]) begin
                q = q >> 1;
                k++;
            end
        end
        x = e - 150 + k;
        if (x > 32) return 8'd0;
        if (x >= 0) mag = q << x;
        else if (-x >= 64) mag = 64'd0;
        else mag = q >> (-x);
        if (mag >= 64'h8000_0000) return 8'd0;
        return f[31] ? 8'(-mag) : mag[7:0];
    endfunction

    // Work out the bytes one accepted lane produces and advance the vertex.
    function automatic void convert_lane(t_in it);
        logic [7:0] b;
        logic [7:0] s;
        int         cnt;
        bit         hit;
        bit         impl;
        bit         vend;
        t_out       r;
        hit = 1'b0;
        impl = 1'b0;
        cnt = 0;
        if (m_src_lanes == m_dst_lanes && m_src_lanes <= MAX_LANES) begin
            hit = 1'b1;
            cnt = m_src_lanes;
        end else if (m_src_usage == USAGE_BLEND && m_dst_usage == USAGE_BLEND_IMPL
                     && m_src_lanes + 1 == m_dst_lanes && m_dst_lanes <= MAX_LANES) begin
            hit = 1'b1;
            cnt = m_dst_lanes;
        end else if ((m_src_usage == USAGE_BLEND_IMPL || m_dst_usage == USAGE_BLEND)
                     && m_dst_lanes + 1 == m_src_lanes && m_src_lanes <= MAX_LANES) begin
            hit = 1'b1;
            cnt = m_dst_lanes;
            impl = 1'b1;
        end
        if (hit && impl && cnt == 0) begin
            // no explicit lanes: only the implied weight comes out
            r = '{byte_value: 8'd255 - vtx_sum, lane_index: 3'd0, vertex_end: 1'b1,
                  run_last: 1'b1, batch_end: it.stream_end};
            expected_bytes.push_back(r);
            lane_cnt = '0;
            vtx_sum = '0;
        end else if (hit && cnt != 0) begin
            b = unorm8_of(it.float_bits);
            vend = (int'(lane_cnt) + 1 >= cnt);
            if (vend && impl) begin
                s = vtx_sum + b;
                r = '{byte_value: b, lane_index: lane_cnt, vertex_end: 1'b0,
                      run_last: 1'b0, batch_end: 1'b0};
                expected_bytes.push_back(r);
                r = '{byte_value: 8'd255 - s, lane_index: 3'(cnt), vertex_end: 1'b1,
                      run_last: 1'b1, batch_end: it.stream_end};
                expected_bytes.push_back(r);
            end else begin
                r = '{byte_value: b, lane_index: lane_cnt, vertex_end: vend,
                      run_last: 1'b1, batch_end: it.stream_end};
                expected_bytes.push_back(r);
            end
            if (vend) begin
                lane_cnt = '0;
                vtx_sum = '0;
            end else begin
                lane_cnt = lane_cnt + 3'd1;
                vtx_sum = vtx_sum + b;
            end
        end
        if (it.stream_end) begin
            lane_cnt = '0;
            vtx_sum = '0;
        end
    endfunction

    // Input driver: advance on acceptance, hold a stalled transaction.
    always @(negedge i_clk) begin
        if (in_valid && !sent) begin
            in_valid <= 1'b1;
        end else begin
            sent = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                in_gap = $urandom_range(0, 7);
                in_valid <= 1'b0;
            end else if (!hold_off && pending_lanes.size() > 0) begin
                in_data <= pending_lanes.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure in bursts.
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            out_gap = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("float_to_unorm8_blend_weights_core: mismatch");
            $finish;
        end
        if (i_rst_n && in_valid && !o_stall) begin
            sent = 1'b1;
            lanes_in++;
            convert_lane(in_data);
        end
        if (i_rst_n && o_valid && !out_stall) begin
            bytes_out++;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result byte_value=%0d", o_data.byte_value);
                fail_cnt++;
            end else begin
                t_out w;
                w = expected_bytes.pop_front();
                if (o_data.byte_value !== w.byte_value) begin
                    $error("byte_value exp %0d got %0d", w.byte_value, o_data.byte_value);
                    fail_cnt++;
                end
                if (o_data.lane_index !== w.lane_index) begin
                    $error("lane_index exp %0d got %0d", w.lane_index, o_data.lane_index);
                    fail_cnt++;
                end
                if (o_data.vertex_end !== w.vertex_end) begin
                    $error("vertex_end exp %0d got %0d", w.vertex_end, o_data.vertex_end);
                    fail_cnt++;
                end
                if (o_data.run_last !== w.run_last) begin
                    $error("run_last exp %0d got %0d", w.run_last, o_data.run_last);
                    fail_cnt++;
                end
                if (o_data.batch_end !== w.batch_end) begin
                    $error("batch_end exp %0d got %0d", w.batch_end, o_data.batch_end);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [3:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SRC_LANES: m_src_lanes = val[2:0];
            REG_DST_LANES: m_dst_lanes = val[2:0];
            REG_SRC_USAGE: m_src_usage = val;
            REG_DST_USAGE: m_dst_usage = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(int sl, int dl, int su, int du);
        write_reg(REG_SRC_LANES, 4'(sl));
        write_reg(REG_DST_LANES, 4'(dl));
        write_reg(REG_SRC_USAGE, 4'(su));
        write_reg(REG_DST_USAGE, 4'(du));
    endtask

    // Wait until every lane went in and every byte came out, then drain.
    // Check at rising edges, where the driven valid is settled.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_lanes.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2, 3: return {1'b0, 8'($urandom_range(112, 127)), 23'($urandom())};
            4: return {1'($urandom()), 8'($urandom_range(126, 160)), 23'($urandom())};
            default: return {1'b0, 8'($urandom_range(118, 126)), 23'($urandom())};
        endcase
    endfunction

    // Queue whole vertices of random lanes, mostly closing batches on a
    // vertex boundary and now and then cutting one short.
    task automatic queue_vertices(int n, int vlen);
        t_in it;
        int  pos;
        pos = 0;
        for (int i = 0; i < n; i++) begin
            it.float_bits = rand_float();
            pos++;
            if (vlen > 0 && pos >= vlen) begin
                pos = 0;
                it.stream_end = ($urandom_range(0, 5) == 0);
            end else begin
                it.stream_end = ($urandom_range(0, 40) == 0);
                if (it.stream_end) pos = 0;
            end
            pending_lanes.push_back(it);
        end
    endtask

    initial begin
        logic [31:0] edge_vals[$];
        int          modes[$][4];
        int          pick;
        int          sl;
        int          dl;
        int          su;
        int          du;
        t_in         it;
        edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                      32'h3F00_0000, 32'h3F7F_FFFF, 32'h7FC0_0000, 32'h7F80_0000,
                      32'hFF80_0000, 32'h4B00_0000, 32'h4F00_0000, 32'hCF00_0000,
                      32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3B80_8081};
        modes = '{'{4, 4, 0, 0}, '{1, 1, 3, 9}, '{2, 2, 7, 8}, '{3, 3, 15, 0},
                  '{3, 4, 7, 8}, '{2, 3, 7, 8}, '{1, 2, 7, 8}, '{0, 1, 7, 8},
                  '{4, 3, 8, 0}, '{3, 2, 0, 7}, '{2, 1, 8, 7}, '{1, 0, 8, 15},
                  '{4, 5, 7, 8}, '{5, 4, 8, 0}, '{5, 5, 0, 0}, '{7, 7, 15, 15},
                  '{0, 0, 0, 0}, '{2, 4, 7, 8}, '{4, 2, 8, 7}, '{3, 4, 0, 8}};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of the float field at reset config, then the
        // implied-last path with the vertex cut short by a batch end and with no explicit lanes.
        foreach (edge_vals[i]) begin
            it.float_bits = edge_vals[i];
            it.stream_end = (i == 15);
            pending_lanes.push_back(it);
        end
        drain();
        set_mode(3, 2, 8, 0);
        pending_lanes.push_back('{float_bits: 32'h3E80_0000, stream_end: 1'b1});
        pending_lanes.push_back('{float_bits: 32'h3E80_0000, stream_end: 1'b0});
        pending_lanes.push_back('{float_bits: 32'h3F40_0000, stream_end: 1'b1});
        drain();
        set_mode(1, 0, 8, 0);
        pending_lanes.push_back('{float_bits: 32'h3F80_0000, stream_end: 1'b0});
        pending_lanes.push_back('{float_bits: 32'hFFFF_FFFF, stream_end: 1'b1});
        drain();

        for (int ph = 0; ph < 34; ph++) begin
            if (ph < modes.size()) pick = ph;
            else pick = $urandom_range(0, modes.size() - 1);
            sl = modes[pick][0];
            dl = modes[pick][1];
            su = modes[pick][2];
            du = modes[pick][3];
            if (ph >= 28 && ph < 31) begin
                sl = $urandom_range(0, 7);
                dl = $urandom_range(0, 7);
                su = $urandom_range(0, 15);
                du = $urandom_range(0, 15);
            end
            quiet = (ph >= 31);
            set_mode(sl, dl, su, du);
            if (ph == 10) begin
                // Let the output side empty completely with the sender paused.
                queue_vertices(20, dl);
                do @(posedge i_clk);
                while (pending_lanes.size() != 0 || in_valid);
                hold_off = 1'b1;
                do @(posedge i_clk);
                while (expected_bytes.size() != 0);
                repeat (3) @(posedge i_clk);
                hold_off = 1'b0;
                queue_vertices(25, dl);
            end else begin
                queue_vertices(45, (sl > dl) ? dl : ((su == 7 && du == 8) ? dl : sl));
            end
            drain();
        end

        $display("covered %0d lanes in, %0d bytes out across 34 mode phases", lanes_in,
                 bytes_out);
        if (fail_cnt == 0) begin
            $display("float_to_unorm8_blend_weights_core: match");
        end else begin
            $display("float_to_unorm8_blend_weights_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
